>>> rtl/core/ptt_pkg.sv
// Shared types and constants of the PID trajectory tracker.
`default_nettype none

package ptt_pkg;

   localparam int FUNC_W     = 2;
   localparam int INDEX_W    = 11;
   localparam int ANGLE_W    = 24;
   localparam int COUNT_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int LEN_W      = 12;
   localparam int TORQUE_W   = 32;
   localparam int ERR_W      = 25;
   localparam int SUM_W      = 19;
   localparam int WIDE_W     = 26;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam int MUL_A_W = WIDE_W;
   localparam int MUL_B_W = GAIN_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LEN  = 4'd3;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET  = 16'sd25600;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RESET = 16'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RESET = 16'sd2560;

   localparam logic signed [MUL_B_W-1:0] DEG_SCALE     = 16'sd17659;
   localparam logic signed [SUM_W-1:0]   SUM_LIMIT_POS = 19'sd256000;
   localparam logic signed [SUM_W-1:0]   SUM_LIMIT_NEG = -19'sd256000;

   localparam logic signed [TORQUE_W-1:0] TORQUE_MAX = 32'sh7fffffff;
   localparam logic signed [TORQUE_W-1:0] TORQUE_MIN = 32'sh80000000;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/ptt_traj_mem.sv
// Trajectory table memory with one write port and one registered read port.
`default_nettype none

module ptt_traj_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic signed [ptt_pkg::ANGLE_W-1:0] wr_data,
   input  logic                              rd_en,
   input  logic [ADDR_W-1:0]                 rd_addr,
   output logic signed [ptt_pkg::ANGLE_W-1:0] rd_data
);
   import ptt_pkg::*;

   logic signed [ANGLE_W-1:0] mem_ff [DEPTH];
   logic signed [ANGLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/ptt_mac.sv
// Shared signed multiplier with a product register and an accumulator.
`default_nettype none

module ptt_mac (
   input  logic                              clock,
   input  ptt_pkg::mac_ctl_type              ctl,
   input  logic signed [ptt_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [ptt_pkg::MUL_B_W-1:0] op_b,
   output logic signed [ptt_pkg::PROD_W-1:0]  prod,
   output logic signed [ptt_pkg::ACC_W-1:0]   acc
);
   import ptt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      if (ctl.mul_en) begin
         prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      end
      if (ctl.acc_load) begin
         acc_in = prod_ext;
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

>>> rtl/core/pid_trajectory_tracker_top.sv
// Top level of the PID trajectory tracker: sequencer, state and ports.
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid/req_ready    func, entry index, target, encoder count
//   rsp_      out        rsp_valid/rsp_ready    torque, measured angle, step, last flag
//   csr_      in         csr_valid/csr_ready    register index and write data
//
// A load or start request is accepted without leaving the idle state. A tick
// while tracking holds req_ready low while the sequencer runs its steps
// (error, proportional, integral, derivative, accumulate, output); the result
// is registered as the output step returns to idle. Reset clears the sequencer
// and tracking state and resets the registers to their defaults; the table
// is not cleared. A stalled result holds the sequencer in its final step.
`default_nettype none

module pid_trajectory_tracker_top #(
   parameter int TRAJ_DEPTH = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ptt_pkg::FUNC_W-1:0]             req_func,
   input  logic [ptt_pkg::INDEX_W-1:0]            req_entry_index,
   input  logic signed [ptt_pkg::ANGLE_W-1:0]     req_target_angle,
   input  logic signed [ptt_pkg::COUNT_W-1:0]     req_encoder_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ptt_pkg::TORQUE_W-1:0]    rsp_torque_cmd,
   output logic signed [ptt_pkg::ANGLE_W-1:0]     rsp_measured_angle,
   output logic [ptt_pkg::INDEX_W-1:0]            rsp_step_number,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ptt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ptt_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import ptt_pkg::*;

   localparam int ADDR_W = $clog2(TRAJ_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_ERR, S_PROP, S_INTEG, S_DERIV, S_ACCUM, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic active_ff, active_in;
   logic [INDEX_W-1:0] step_ff, step_in;
   logic signed [SUM_W-1:0] esum_ff, esum_in;
   logic signed [ERR_W-1:0] prev_ff, prev_in;
   logic signed [GAIN_W-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic tgt_ok_ff, tgt_ok_in;
   logic signed [ANGLE_W-1:0] meas_ff, meas_in;
   logic signed [ERR_W-1:0] e_ff, e_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [WIDE_W-1:0] diff_ff, diff_in;
   logic signed [TORQUE_W-1:0] out_torque_ff, out_torque_in;
   logic signed [ANGLE_W-1:0] out_meas_ff, out_meas_in;
   logic [INDEX_W-1:0] out_step_ff, out_step_in;
   logic out_last_ff, out_last_in;

   logic req_fire, csr_fire;
   logic [31:0] wr_ext, rd_ext;
   logic wr_en, rd_en;
   logic signed [ANGLE_W-1:0] rd_data, target;
   mac_ctl_type mac_ctl;
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0] acc;
   logic signed [WIDE_W-1:0] sum_wide;
   logic [LEN_W-1:0] step_next;
   logic fin, sat_fits;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign wr_ext = 32'(req_entry_index);
   assign rd_ext = 32'(step_ff);
   assign wr_en  = req_fire && (req_func == FUNC_LOAD) && (wr_ext < 32'(TRAJ_DEPTH));
   assign rd_en  = req_fire && (req_func == FUNC_TICK) && active_ff;

   ptt_traj_mem #(
      .DEPTH (TRAJ_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_traj_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_ext[ADDR_W-1:0]),
      .wr_data(req_target_angle),
      .rd_en  (rd_en),
      .rd_addr(rd_ext[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   ptt_mac u_mac (
      .clock(clock),
      .ctl  (mac_ctl),
      .op_a (op_a),
      .op_b (op_b),
      .prod (prod),
      .acc  (acc)
   );

   assign target    = tgt_ok_ff ? rd_data : '0;
   assign sum_wide  = WIDE_W'(esum_ff) + WIDE_W'(e_ff);
   assign step_next = LEN_W'(step_ff) + LEN_W'(1);
   assign fin       = (step_next >= len_ff);
   assign sat_fits  = (&acc[ACC_W-1:TORQUE_W+7]) || !(|acc[ACC_W-1:TORQUE_W+7]);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      active_in     = active_ff;
      step_in       = step_ff;
      esum_in       = esum_ff;
      prev_in       = prev_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      len_in        = len_ff;
      tgt_ok_in     = tgt_ok_ff;
      meas_in       = meas_ff;
      e_in          = e_ff;
      sum_in        = sum_ff;
      diff_in       = diff_ff;
      out_torque_in = out_torque_ff;
      out_meas_in   = out_meas_ff;
      out_step_in   = out_step_ff;
      out_last_in   = out_last_ff;
      mac_ctl       = '0;
      op_a          = MUL_A_W'(req_encoder_count);
      op_b          = DEG_SCALE;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  kp_in = csr_wdata;
            CSR_INTEG_GAIN: ki_in = csr_wdata;
            CSR_DERIV_GAIN: kd_in = csr_wdata;
            CSR_TRACK_LEN:  len_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_func == FUNC_START && len_ff != '0) begin
                  active_in = 1'b1;
               end
               if (rd_en) begin
                  mac_ctl.mul_en = 1'b1;
                  tgt_ok_in      = (rd_ext < 32'(TRAJ_DEPTH));
                  state_in       = S_ERR;
               end
            end
         end
         S_ERR: begin
            meas_in  = prod[ANGLE_W+7:8];
            e_in     = ERR_W'(target) - ERR_W'($signed(prod[ANGLE_W+7:8]));
            state_in = S_PROP;
         end
         S_PROP: begin
            op_a           = MUL_A_W'(e_ff);
            op_b           = kp_ff;
            mac_ctl.mul_en = 1'b1;
            if (sum_wide > WIDE_W'(SUM_LIMIT_POS)) begin
               sum_in = SUM_LIMIT_POS;
            end else if (sum_wide < WIDE_W'(SUM_LIMIT_NEG)) begin
               sum_in = SUM_LIMIT_NEG;
            end else begin
               sum_in = sum_wide[SUM_W-1:0];
            end
            diff_in  = WIDE_W'(e_ff) - WIDE_W'(prev_ff);
            state_in = S_INTEG;
         end
         S_INTEG: begin
            op_a             = MUL_A_W'(sum_ff);
            op_b             = ki_ff;
            mac_ctl.mul_en   = 1'b1;
            mac_ctl.acc_load = 1'b1;
            state_in         = S_DERIV;
         end
         S_DERIV: begin
            op_a            = diff_ff;
            op_b            = kd_ff;
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.acc_add = 1'b1;
            state_in        = S_ACCUM;
         end
         S_ACCUM: begin
            mac_ctl.acc_add = 1'b1;
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (sat_fits) begin
                  out_torque_in = acc[TORQUE_W+7:8];
               end else if (acc[ACC_W-1]) begin
                  out_torque_in = TORQUE_MIN;
               end else begin
                  out_torque_in = TORQUE_MAX;
               end
               out_meas_in = meas_ff;
               out_step_in = step_ff;
               out_last_in = fin;
               if (fin) begin
                  step_in   = '0;
                  esum_in   = '0;
                  prev_in   = '0;
                  active_in = 1'b0;
               end else begin
                  step_in = step_next[INDEX_W-1:0];
                  esum_in = sum_ff;
                  prev_in = e_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         step_ff      <= '0;
         esum_ff      <= '0;
         prev_ff      <= '0;
         kp_ff        <= PROP_GAIN_RESET;
         ki_ff        <= INTEG_GAIN_RESET;
         kd_ff        <= DERIV_GAIN_RESET;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
         esum_ff      <= esum_in;
         prev_ff      <= prev_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         len_ff       <= len_in;
      end
      tgt_ok_ff     <= tgt_ok_in;
      meas_ff       <= meas_in;
      e_ff          <= e_in;
      sum_ff        <= sum_in;
      diff_ff       <= diff_in;
      out_torque_ff <= out_torque_in;
      out_meas_ff   <= out_meas_in;
      out_step_ff   <= out_step_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_torque_cmd     = out_torque_ff;
   assign rsp_measured_angle = out_meas_ff;
   assign rsp_step_number    = out_step_ff;
   assign rsp_last           = out_last_ff;

endmodule

`default_nettype wire
